FILE: design/wavetable_oscillator_interp_unit_defines.svh
// Assertion macros used by the oscillator checker.
`ifndef WAVETABLE_OSCILLATOR_INTERP_UNIT_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_INTERP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WTOI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WTOI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/wtoi_pkg.sv
// Shared types and constants for the wavetable oscillator.
`default_nettype none

package wtoi_pkg;

  localparam int unsigned SEGMENTS   = 32;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CNT_W      = 34;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CNT_W-1:0]  ONE_Q16    = 34'h0_0001_0000;
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd6144000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Code 3 behaves like a full clear.
  typedef enum logic [1:0] {
    RESTART_NONE      = 2'd0,
    RESTART_RELOAD    = 2'd1,
    RESTART_CLEAR     = 2'd2,
    RESTART_CLEAR_ALT = 2'd3
  } restart_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STEP_SIZE = 3'd0,
    REG_WAVE_LOW  = 3'd1,
    REG_WAVE_HIGH = 3'd2,
    REG_LEVELS_A  = 3'd3,
    REG_LEVELS_B  = 3'd4,
    REG_LEVELS_C  = 3'd5,
    REG_LEVELS_D  = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

FILE: design/wtoi_interp.sv
// Linear interpolation between the previous sample and the new level.
`default_nettype none

module wtoi_interp (
  input  wtoi_pkg::sample_t                 prev,
  input  wtoi_pkg::sample_t                 level,
  input  logic [wtoi_pkg::FRAC_W-1:0]       frac,
  output wtoi_pkg::sample_t                 sample
);

  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [34:0] prod_adj;
  logic signed [18:0] step_q;
  logic signed [17:0] sum;

  assign diff = {level[15], level} - {prev[15], prev};
  assign prod = diff * $signed({1'b0, frac});

  // bias negative products so the shift truncates toward zero
  assign prod_adj = prod[34] ? prod + 35'sd65535 : prod;
  assign step_q   = prod_adj[34:16];

  // result stays between prev and level, so the low 16 bits are exact
  assign sum    = {{2{prev[15]}}, prev} + step_q[17:0];
  assign sample = sum[15:0];

endmodule

`default_nettype wire

FILE: design/wavetable_oscillator_interp_unit.sv
// A sample shows on out_tdata in the cycle after its input transaction.
// Throughput: one transaction per cycle unless stalled; the phase, segment
// and interpolation update for one tick, with its single 17x18 multiply, fits
// between the state registers and the output register. Reset (synchronous,
// rst_n low) loads counter and step_size with 6144000, clears index, previous
// sample, waveform and level registers, and empties the output register.
`default_nettype none

module wavetable_oscillator_interp_unit #(
  parameter int unsigned SEGMENTS = wtoi_pkg::SEGMENTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [1:0] restart, [7:2] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,  // [15:0] sample
  input  logic                                cfg_we,
  input  logic [wtoi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wtoi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [wtoi_pkg::STEP_W-1:0] step_r;
  logic [63:0]                 wave_low_r;
  logic [63:0]                 wave_high_r;
  logic [63:0]                 levels_a_r;
  logic [63:0]                 levels_b_r;
  logic [63:0]                 levels_c_r;
  logic [63:0]                 levels_d_r;

  // oscillator state
  logic [wtoi_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [wtoi_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  wtoi_pkg::sample_t           prev_r, prev_nxt;

  logic                        out_valid_r;
  wtoi_pkg::sample_t           out_data_r;

  logic                        accept;
  wtoi_pkg::restart_t          restart;
  logic [wtoi_pkg::CNT_W-1:0]  cnt_eff;
  logic [wtoi_pkg::IDX_W-1:0]  idx_eff;
  wtoi_pkg::sample_t           prev_eff;
  logic                        hold;
  logic                        advance;
  logic [wtoi_pkg::IDX_W:0]    idx_inc;
  logic [wtoi_pkg::IDX_W-1:0]  idx_adv;
  logic [wtoi_pkg::IDX_W-1:0]  look_idx;
  logic [127:0]                wave_bytes;
  logic [255:0]                level_bits;
  logic [7:0]                  wave_byte;
  logic [3:0]                  seg_val;
  wtoi_pkg::sample_t           level;
  wtoi_pkg::sample_t           interp_sample;
  wtoi_pkg::sample_t           sample_nxt;
  logic [wtoi_pkg::CNT_W-1:0]  cnt_sum;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign restart = wtoi_pkg::restart_t'(in_tdata[1:0]);

  // restart takes effect before this tick's sample
  always_comb begin
    cnt_eff  = cnt_r;
    idx_eff  = idx_r;
    prev_eff = prev_r;
    unique case (restart)
      wtoi_pkg::RESTART_NONE: begin
      end
      wtoi_pkg::RESTART_RELOAD: begin
        cnt_eff = {2'b00, step_r};
      end
      wtoi_pkg::RESTART_CLEAR, wtoi_pkg::RESTART_CLEAR_ALT: begin
        cnt_eff  = {2'b00, step_r};
        idx_eff  = '0;
        prev_eff = '0;
      end
      default: begin
      end
    endcase
  end

  assign hold    = cnt_eff > wtoi_pkg::ONE_Q16;
  assign advance = !hold && (cnt_eff != '0);

  assign idx_inc = {1'b0, idx_eff} + 6'd1;
  assign idx_adv = (idx_inc >= 6'(SEGMENTS)) ? '0 : idx_inc[wtoi_pkg::IDX_W-1:0];

  assign look_idx = advance ? idx_adv : idx_eff;

  // even index takes the high nibble of its byte
  assign wave_bytes = {wave_high_r, wave_low_r};
  assign wave_byte  = wave_bytes[look_idx[4:1] * 8 +: 8];
  assign seg_val    = look_idx[0] ? wave_byte[3:0] : wave_byte[7:4];
  assign level_bits = {levels_d_r, levels_c_r, levels_b_r, levels_a_r};
  assign level      = level_bits[seg_val * 16 +: 16];

  wtoi_interp u_interp (
    .prev   (prev_eff),
    .level  (level),
    .frac   (cnt_eff[wtoi_pkg::FRAC_W-1:0]),
    .sample (interp_sample)
  );

  assign cnt_sum = cnt_eff + {2'b00, step_r};

  always_comb begin
    priority if (hold) begin
      sample_nxt = level;
      cnt_nxt    = cnt_eff - wtoi_pkg::ONE_Q16;
      idx_nxt    = idx_eff;
    end else if (advance) begin
      sample_nxt = interp_sample;
      cnt_nxt    = (cnt_sum > wtoi_pkg::ONE_Q16) ? cnt_sum - wtoi_pkg::ONE_Q16 : cnt_sum;
      idx_nxt    = idx_adv;
    end else begin
      sample_nxt = '0;
      cnt_nxt    = cnt_eff;
      idx_nxt    = idx_eff;
    end
    prev_nxt = sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= {2'b00, wtoi_pkg::STEP_RESET};
      idx_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        idx_r       <= idx_nxt;
        prev_r      <= prev_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= wtoi_pkg::STEP_RESET;
      wave_low_r  <= '0;
      wave_high_r <= '0;
      levels_a_r  <= '0;
      levels_b_r  <= '0;
      levels_c_r  <= '0;
      levels_d_r  <= '0;
    end else if (cfg_we) begin
      unique case (wtoi_pkg::reg_idx_t'(cfg_addr))
        wtoi_pkg::REG_STEP_SIZE: step_r      <= cfg_wdata[wtoi_pkg::STEP_W-1:0];
        wtoi_pkg::REG_WAVE_LOW:  wave_low_r  <= cfg_wdata;
        wtoi_pkg::REG_WAVE_HIGH: wave_high_r <= cfg_wdata;
        wtoi_pkg::REG_LEVELS_A:  levels_a_r  <= cfg_wdata;
        wtoi_pkg::REG_LEVELS_B:  levels_b_r  <= cfg_wdata;
        wtoi_pkg::REG_LEVELS_C:  levels_c_r  <= cfg_wdata;
        wtoi_pkg::REG_LEVELS_D:  levels_d_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/wtoi_checker.sv
// Port-level checker for the oscillator, bound to the top level.
`default_nettype none
`include "wavetable_oscillator_interp_unit_defines.svh"

module wtoi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [15:0]                     out_tdata
);

  // every input transaction yields a sample in the next cycle
  `WTOI_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready, out_tvalid, "no sample after transaction")

  // empty output register means the block takes input
  `WTOI_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "not ready with empty output")

  // a waiting sample is never overwritten
  `WTOI_ASSERT_NOW(a_no_overwrite, out_tvalid && !out_tready, !in_tready, "ready while sample stalled")

  `WTOI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled sample changed")

endmodule

bind wavetable_oscillator_interp_unit wtoi_checker u_wtoi_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the wavetable oscillator: predicts every sample and checks the stream.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [wtoi_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;  // past the last register
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_CYCLES = 2;
  localparam int DRAIN_CYCLES  = 4;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;   // [1:0] restart, [7:2] zero
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;         // [15:0] sample
  logic                            cfg_we     = 1'b0;
  logic [wtoi_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [wtoi_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  always #5 clk = ~clk;

  wavetable_oscillator_interp_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Oscillator state as the testbench sees it
  logic [wtoi_pkg::STEP_W-1:0] osc_step;
  logic [63:0]                 osc_wave [2];
  logic [63:0]                 osc_levels [4];
  logic [wtoi_pkg::CNT_W-1:0]  osc_cnt;
  logic [wtoi_pkg::IDX_W-1:0]  osc_idx;
  wtoi_pkg::sample_t           osc_prev;

  wtoi_pkg::sample_t exp_samples [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold_left   = 0;

  int fail_count = 0;
  int n_checked  = 0;
  int n_level    = 0;
  int n_interp   = 0;
  int n_zero     = 0;
  int n_wraps    = 0;
  int n_restarts = 0;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  task automatic osc_model_reset();
    osc_step  = wtoi_pkg::STEP_RESET;
    osc_wave  = '{default: '0};
    osc_levels = '{default: '0};
    osc_cnt   = {2'b00, wtoi_pkg::STEP_RESET};
    osc_idx   = '0;
    osc_prev  = '0;
  endtask

  function automatic wtoi_pkg::sample_t osc_level_at(input logic [wtoi_pkg::IDX_W-1:0] idx);
    logic [3:0] byte_no;
    logic [7:0] wbyte;
    logic [3:0] seg;
    byte_no = idx[4:1];
    wbyte   = osc_wave[byte_no[3]][byte_no[2:0]*8 +: 8];
    // even index takes the high nibble
    seg     = idx[0] ? wbyte[3:0] : wbyte[7:4];
    return osc_levels[seg[3:2]][seg[1:0]*16 +: 16];
  endfunction

  function automatic wtoi_pkg::sample_t osc_tick(input wtoi_pkg::restart_t code);
    int                         lvl;
    int                         diff;
    longint                     prod;
    longint                     mag;
    logic [wtoi_pkg::CNT_W:0]   sum;
    wtoi_pkg::sample_t          res;
    if (code != wtoi_pkg::RESTART_NONE) begin
      n_restarts++;
      osc_cnt = {2'b00, osc_step};
      if (code == wtoi_pkg::RESTART_CLEAR || code == wtoi_pkg::RESTART_CLEAR_ALT) begin
        osc_idx  = '0;
        osc_prev = '0;
      end
    end
    if (osc_cnt > wtoi_pkg::ONE_Q16) begin
      res = osc_level_at(osc_idx);
      osc_cnt = osc_cnt - wtoi_pkg::ONE_Q16;
      n_level++;
    end else if (osc_cnt != '0) begin
      if (int'(osc_idx) + 1 >= wtoi_pkg::SEGMENTS) begin
        osc_idx = '0;
        n_wraps++;
      end else begin
        osc_idx = osc_idx + 1'b1;
      end
      lvl  = osc_level_at(osc_idx);
      diff = lvl - int'(osc_prev);
      prod = longint'(diff) * longint'(osc_cnt);
      // truncate toward zero
      if (prod < 0) begin
        mag = (-prod) >> 16;
        res = 16'(int'(osc_prev) - int'(mag));
      end else begin
        mag = prod >> 16;
        res = 16'(int'(osc_prev) + int'(mag));
      end
      sum = osc_cnt + osc_step;
      osc_cnt = sum[wtoi_pkg::CNT_W-1:0];
      if (osc_cnt > wtoi_pkg::ONE_Q16) osc_cnt = osc_cnt - wtoi_pkg::ONE_Q16;
      n_interp++;
    end else begin
      res = '0;
      n_zero++;
    end
    osc_prev = res;
    return res;
  endfunction

  task automatic cfg_write(input logic [wtoi_pkg::CFG_ADDR_W-1:0] addr, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      wtoi_pkg::REG_STEP_SIZE: osc_step      = data[wtoi_pkg::STEP_W-1:0];
      wtoi_pkg::REG_WAVE_LOW:  osc_wave[0]   = data;
      wtoi_pkg::REG_WAVE_HIGH: osc_wave[1]   = data;
      wtoi_pkg::REG_LEVELS_A:  osc_levels[0] = data;
      wtoi_pkg::REG_LEVELS_B:  osc_levels[1] = data;
      wtoi_pkg::REG_LEVELS_C:  osc_levels[2] = data;
      wtoi_pkg::REG_LEVELS_D:  osc_levels[3] = data;
      default: ;  // ignored by the block
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input wtoi_pkg::restart_t code);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_samples.push_back(osc_tick(code));
  endtask

  // Sender holds off until every outstanding sample has been checked
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (exp_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic wtoi_pkg::restart_t pick_restart();
    if ($urandom_range(99) < 85) return wtoi_pkg::RESTART_NONE;
    return wtoi_pkg::restart_t'($urandom_range(3, 1));
  endfunction

  function automatic logic [wtoi_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0001_0000;
      3:       return 32'd1;
      4, 5, 6, 7: return $urandom_range(32'h0004_0000, 32'h0000_4000);
      8:       return $urandom_range(32'h0040_0000, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : sample_check
    wtoi_pkg::sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_samples.size() == 0) begin
        note_failure($sformatf("unexpected sample %0d", $signed(out_tdata)));
      end else begin
        want = exp_samples.pop_front();
        n_checked++;
        if (out_tdata !== want)
          note_failure($sformatf("sample #%0d: expected %0d, got %0d",
                                 n_checked, want, $signed(out_tdata)));
      end
    end
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_write(wtoi_pkg::REG_LEVELS_A, {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
    cfg_write(wtoi_pkg::REG_LEVELS_B, {16'h4000, 16'hC000, 16'h1234, 16'h0001});
    cfg_write(wtoi_pkg::REG_LEVELS_C, {16'h7FFE, 16'h8001, 16'hEDCB, 16'h0100});
    cfg_write(wtoi_pkg::REG_LEVELS_D, {16'h2AAA, 16'hD555, 16'h0FFF, 16'hF000});
    // segments 0,1 swing from +full scale to -full scale
    cfg_write(wtoi_pkg::REG_WAVE_LOW,  64'h1FE2_D3C4_B5A6_9701);
    cfg_write(wtoi_pkg::REG_WAVE_HIGH, 64'h1001_F00F_8877_3CC3);
    cfg_write(REG_UNUSED, '1);
    // upper half of the data word must not reach the step register
    cfg_write(wtoi_pkg::REG_STEP_SIZE, {32'hFFFF_FFFF, 32'h0001_0000});
    send_tick(wtoi_pkg::RESTART_CLEAR);
    repeat (4) send_tick(wtoi_pkg::RESTART_NONE);
    wait_idle();
    cfg_write(wtoi_pkg::REG_STEP_SIZE, 64'd1);
    send_tick(wtoi_pkg::RESTART_RELOAD);
    repeat (3) send_tick(wtoi_pkg::RESTART_NONE);
    wait_idle();
    cfg_write(wtoi_pkg::REG_STEP_SIZE, 64'hFFFF_FFFF);
    send_tick(wtoi_pkg::RESTART_CLEAR_ALT);
    repeat (3) send_tick(wtoi_pkg::RESTART_NONE);
    wait_idle();
    cfg_write(wtoi_pkg::REG_STEP_SIZE, 64'h0001_8000);
    send_tick(wtoi_pkg::RESTART_RELOAD);
    repeat (4) send_tick(wtoi_pkg::RESTART_NONE);
    wait_idle();
    // a new step takes effect at once; after the reload the counter sits at zero
    cfg_write(wtoi_pkg::REG_STEP_SIZE, 64'd0);
    repeat (2) send_tick(wtoi_pkg::RESTART_NONE);
    send_tick(wtoi_pkg::RESTART_RELOAD);
    send_tick(wtoi_pkg::RESTART_NONE);
    send_tick(wtoi_pkg::RESTART_CLEAR);
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      cfg_write(wtoi_pkg::REG_STEP_SIZE, {32'($urandom), pick_step()});
      cfg_write(wtoi_pkg::REG_WAVE_LOW,  {$urandom, $urandom});
      cfg_write(wtoi_pkg::REG_WAVE_HIGH, {$urandom, $urandom});
      cfg_write(wtoi_pkg::REG_LEVELS_A,  {$urandom, $urandom});
      cfg_write(wtoi_pkg::REG_LEVELS_B,  {$urandom, $urandom});
      cfg_write(wtoi_pkg::REG_LEVELS_C,  {$urandom, $urandom});
      cfg_write(wtoi_pkg::REG_LEVELS_D,  {$urandom, $urandom});
      send_tick(wtoi_pkg::RESTART_CLEAR);
      repeat (PHASE_ITEMS) send_tick(pick_restart());
    end
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver blocks for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    cfg_write(wtoi_pkg::REG_STEP_SIZE, 64'h0000_8000);
    rx_hold_left = 64;
    repeat (30) send_tick(pick_restart());
    wait_idle();
  endtask

  initial begin
    osc_model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_samples.size() != 0)
      note_failure($sformatf("%0d samples never arrived", exp_samples.size()));
    $display("Checked %0d samples: %0d level, %0d interpolated, %0d zero-counter ticks",
             n_checked, n_level, n_interp, n_zero);
    $display("%0d restarts, %0d index wraps, %0d random config phases, %0d failures",
             n_restarts, n_wraps, RAND_PHASES, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d samples still outstanding", exp_samples.size());
    $display("Verification failed");
    $finish;
  end

endmodule
